// ===== sv/rtyc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtyc_pkg
// Shared widths, coefficients and pipeline types for the RGB to YPbPr core.
// ----------------------------------------------------------------------------
package rtyc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int OUT_W     = 16;
  localparam int PROD_W    = 32;
  localparam int MAG_W     = 32;
  localparam int REM_W     = 33;
  localparam int DIV_W     = SAMPLE_W + 1;
  localparam int QUO_BITS  = 16;
  localparam int NUM_LANES = 3;

  // Lane order of the three results.
  localparam int LANE_Y  = 0;
  localparam int LANE_PB = 1;
  localparam int LANE_PR = 2;

  // Registers from an accepted request to its result strobe: input register,
  // three weighting stages, one cell per quotient bit, output register.
  localparam int PIPE_DEPTH = QUO_BITS + 5;

  // BT.601 weights in Q0.16; each row sums to 65536 (Y) or 0 (Pb, Pr).
  localparam logic [SAMPLE_W-1:0] Y_R_COEF  = 16'd19595;
  localparam logic [SAMPLE_W-1:0] Y_G_COEF  = 16'd38470;
  localparam logic [SAMPLE_W-1:0] Y_B_COEF  = 16'd7471;
  localparam logic [SAMPLE_W-1:0] PB_R_COEF = 16'd11058;
  localparam logic [SAMPLE_W-1:0] PB_G_COEF = 16'd21710;
  localparam logic [SAMPLE_W-1:0] PR_G_COEF = 16'd27439;
  localparam logic [SAMPLE_W-1:0] PR_B_COEF = 16'd5329;

  // Saturation limits: 1.0 for luma, 0.5 for the color differences.
  localparam logic [QUO_BITS-1:0] LUMA_LIMIT = 16'd32768;
  localparam logic [QUO_BITS-1:0] DIFF_LIMIT = 16'd16384;

  localparam logic [SAMPLE_W-1:0] MAX_VALUE_RESET = 16'd255;

  typedef struct packed {
    logic                neg;
    logic                ovf;
    logic [REM_W-1:0]    rem;
    logic [QUO_BITS-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic [DIV_W-1:0]            div;
    lane_t [NUM_LANES-1:0]       lane;
  } cell_bus_t;

endpackage

// ===== sv/rgb_to_ypbpr_converter_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_ypbpr_converter_core
// BT.601 RGB to YPbPr conversion normalized by a programmable maximum value.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock (busy never rises) and strobes out_valid
// with its result in request order; the receiver cannot stall, so every
// result is shown for one cycle only. Each request passes through an input
// register, three weighting stages, one divider cell per quotient bit (16
// cells) and the output register. max_value is sampled when a request is
// accepted, and a value of zero acts as one. Luma saturates to 0..32768, Pb
// and Pr to -16384..16384.
module rgb_to_ypbpr_converter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rtyc_pkg::SAMPLE_W-1:0] in_red,
  input  logic [rtyc_pkg::SAMPLE_W-1:0] in_green,
  input  logic [rtyc_pkg::SAMPLE_W-1:0] in_blue,
  output logic                          out_valid,
  output logic [rtyc_pkg::OUT_W-1:0]    out_luma,
  output logic signed [rtyc_pkg::OUT_W-1:0] out_blue_diff,
  output logic signed [rtyc_pkg::OUT_W-1:0] out_red_diff,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rtyc_pkg::SAMPLE_W-1:0] cfg_data
);

  logic [rtyc_pkg::SAMPLE_W-1:0] max_value_r;
  logic                          in_valid_r;
  logic [rtyc_pkg::SAMPLE_W-1:0] red_r, green_r, blue_r, max_r;
  logic                          accept;

  logic                chain_valid [rtyc_pkg::QUO_BITS+1];
  rtyc_pkg::cell_bus_t chain_bus   [rtyc_pkg::QUO_BITS+1];

  logic                       out_valid_r;
  logic [rtyc_pkg::OUT_W-1:0] res_r   [rtyc_pkg::NUM_LANES];
  logic [rtyc_pkg::OUT_W-1:0] res_nxt [rtyc_pkg::NUM_LANES];
  logic [rtyc_pkg::QUO_BITS-1:0] limit [rtyc_pkg::NUM_LANES];
  logic [rtyc_pkg::QUO_BITS-1:0] mag   [rtyc_pkg::NUM_LANES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r <= rtyc_pkg::MAX_VALUE_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_value_r <= cfg_data;
      end
      in_valid_r  <= accept;
      out_valid_r <= chain_valid[rtyc_pkg::QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= in_red;
    green_r <= in_green;
    blue_r  <= in_blue;
    max_r   <= (max_value_r == '0) ? 16'd1 : max_value_r;
    for (int i = 0; i < rtyc_pkg::NUM_LANES; i++) begin
      res_r[i] <= res_nxt[i];
    end
  end

  rtyc_weigh u_weigh (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid_r),
    .red       (red_r),
    .green     (green_r),
    .blue      (blue_r),
    .max_val   (max_r),
    .out_valid (chain_valid[0]),
    .out_bus   (chain_bus[0])
  );

  for (genvar k = 0; k < rtyc_pkg::QUO_BITS; k++) begin : g_cell
    rtyc_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[k]),
      .in_bus    (chain_bus[k]),
      .out_valid (chain_valid[k+1]),
      .out_bus   (chain_bus[k+1])
    );
  end

  // Clamp the quotient magnitude, then restore the sign.
  always_comb begin
    limit[rtyc_pkg::LANE_Y]  = rtyc_pkg::LUMA_LIMIT;
    limit[rtyc_pkg::LANE_PB] = rtyc_pkg::DIFF_LIMIT;
    limit[rtyc_pkg::LANE_PR] = rtyc_pkg::DIFF_LIMIT;
    for (int i = 0; i < rtyc_pkg::NUM_LANES; i++) begin
      if (chain_bus[rtyc_pkg::QUO_BITS].lane[i].ovf ||
          chain_bus[rtyc_pkg::QUO_BITS].lane[i].quo > limit[i]) begin
        mag[i] = limit[i];
      end else begin
        mag[i] = chain_bus[rtyc_pkg::QUO_BITS].lane[i].quo;
      end
      res_nxt[i] = chain_bus[rtyc_pkg::QUO_BITS].lane[i].neg ? -mag[i] : mag[i];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_luma      = res_r[rtyc_pkg::LANE_Y];
  assign out_blue_diff = res_r[rtyc_pkg::LANE_PB];
  assign out_red_diff  = res_r[rtyc_pkg::LANE_PR];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(rtyc_pkg::PIPE_DEPTH) out_valid)
    else $error("request did not produce a result at the expected latency");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_luma <= rtyc_pkg::LUMA_LIMIT)
    else $error("luma above 1.0");

  a_pb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_blue_diff) <= $signed(16'sd16384) &&
                   $signed(out_blue_diff) >= $signed(-16'sd16384)))
    else $error("Pb outside +/-0.5");

  a_pr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_red_diff) <= $signed(16'sd16384) &&
                   $signed(out_red_diff) >= $signed(-16'sd16384)))
    else $error("Pr outside +/-0.5");

endmodule

// ===== sv/rtyc_weigh.sv =====
// ----------------------------------------------------------------------------
// rtyc_weigh
// Weighted sums, sign and magnitude, and divider setup in three stages.
// ----------------------------------------------------------------------------
module rtyc_weigh (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [rtyc_pkg::SAMPLE_W-1:0] red,
  input  logic [rtyc_pkg::SAMPLE_W-1:0] green,
  input  logic [rtyc_pkg::SAMPLE_W-1:0] blue,
  input  logic [rtyc_pkg::SAMPLE_W-1:0] max_val,
  output logic                          out_valid,
  output rtyc_pkg::cell_bus_t           out_bus
);

  // Stage 1: constant products
  logic                          s1_valid_r;
  logic [rtyc_pkg::SAMPLE_W-1:0] s1_max_r;
  logic [rtyc_pkg::PROD_W-1:0]   y_r_r, y_g_r, y_b_r;
  logic [rtyc_pkg::PROD_W-1:0]   pb_r_r, pb_g_r, pr_g_r, pr_b_r;
  logic [rtyc_pkg::PROD_W-1:0]   pb_pos_r, pr_pos_r;

  // Stage 2: sums
  logic                          s2_valid_r;
  logic [rtyc_pkg::SAMPLE_W-1:0] s2_max_r;
  logic [rtyc_pkg::PROD_W-1:0]   y_sum_r;
  logic signed [rtyc_pkg::REM_W-1:0] pb_diff_r, pr_diff_r;

  // Stage 3: magnitude plus rounding term, overflow check
  logic                       s3_valid_r;
  rtyc_pkg::cell_bus_t        s3_bus_r, s3_bus_nxt;

  logic signed [rtyc_pkg::REM_W-1:0] diff [rtyc_pkg::NUM_LANES];
  logic [rtyc_pkg::MAG_W-1:0]        mag  [rtyc_pkg::NUM_LANES];
  logic [rtyc_pkg::DIV_W-1:0]        div;
  logic [rtyc_pkg::REM_W-1:0]        ovf_bound;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_max_r <= max_val;
    y_r_r    <= 32'(rtyc_pkg::Y_R_COEF)  * 32'(red);
    y_g_r    <= 32'(rtyc_pkg::Y_G_COEF)  * 32'(green);
    y_b_r    <= 32'(rtyc_pkg::Y_B_COEF)  * 32'(blue);
    pb_r_r   <= 32'(rtyc_pkg::PB_R_COEF) * 32'(red);
    pb_g_r   <= 32'(rtyc_pkg::PB_G_COEF) * 32'(green);
    pr_g_r   <= 32'(rtyc_pkg::PR_G_COEF) * 32'(green);
    pr_b_r   <= 32'(rtyc_pkg::PR_B_COEF) * 32'(blue);
    pb_pos_r <= {1'b0, blue, 15'b0};
    pr_pos_r <= {1'b0, red, 15'b0};

    s2_max_r  <= s1_max_r;
    y_sum_r   <= y_r_r + y_g_r + y_b_r;
    pb_diff_r <= $signed({1'b0, pb_pos_r}) - $signed({1'b0, pb_r_r + pb_g_r});
    pr_diff_r <= $signed({1'b0, pr_pos_r}) - $signed({1'b0, pr_g_r + pr_b_r});

    s3_bus_r <= s3_bus_nxt;
  end

  always_comb begin
    diff[rtyc_pkg::LANE_Y]  = $signed({1'b0, y_sum_r});
    diff[rtyc_pkg::LANE_PB] = pb_diff_r;
    diff[rtyc_pkg::LANE_PR] = pr_diff_r;
    div        = {s2_max_r, 1'b0};
    ovf_bound  = {div, 16'b0};
    s3_bus_nxt = '0;
    s3_bus_nxt.div = div;
    for (int i = 0; i < rtyc_pkg::NUM_LANES; i++) begin
      mag[i] = diff[i][rtyc_pkg::REM_W-1] ? 32'(-diff[i]) : 32'(diff[i]);
      s3_bus_nxt.lane[i].neg = diff[i][rtyc_pkg::REM_W-1];
      // (mag + m) / (2m) is the rounded quotient
      s3_bus_nxt.lane[i].rem = {1'b0, mag[i]} + 33'(s2_max_r);
      s3_bus_nxt.lane[i].ovf = s3_bus_nxt.lane[i].rem >= ovf_bound;
      s3_bus_nxt.lane[i].quo = '0;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_bus   = s3_bus_r;

endmodule

// ===== sv/rtyc_div_cell.sv =====
// ----------------------------------------------------------------------------
// rtyc_div_cell
// One restoring-division step: resolves one quotient bit on each lane.
// ----------------------------------------------------------------------------
module rtyc_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  rtyc_pkg::cell_bus_t in_bus,
  output logic                out_valid,
  output rtyc_pkg::cell_bus_t out_bus
);

  logic                       valid_r;
  rtyc_pkg::cell_bus_t        bus_r, bus_nxt;
  logic [rtyc_pkg::REM_W-1:0] trial;
  logic [rtyc_pkg::REM_W-1:0] diff [rtyc_pkg::NUM_LANES];
  logic                       take [rtyc_pkg::NUM_LANES];

  always_comb begin
    bus_nxt = in_bus;
    trial   = {1'b0, in_bus.div, 15'b0};
    for (int i = 0; i < rtyc_pkg::NUM_LANES; i++) begin
      take[i] = in_bus.lane[i].rem >= trial;
      diff[i] = take[i] ? in_bus.lane[i].rem - trial : in_bus.lane[i].rem;
      // advance the remainder one bit against the fixed trial divisor
      bus_nxt.lane[i].rem = {diff[i][rtyc_pkg::REM_W-2:0], 1'b0};
      bus_nxt.lane[i].quo = {in_bus.lane[i].quo[rtyc_pkg::QUO_BITS-2:0], take[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    bus_r <= bus_nxt;
  end

  assign out_valid = valid_r;
  assign out_bus   = bus_r;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the RGB to YPbPr core against a behavioral BT.601 predictor.
// ----------------------------------------------------------------------------
// Pixel requests are queued by the stimulus process and fed to the core by a
// clocked driver with random gaps. Each accepted pixel is converted by the
// predictor with the max_value in force and its expected Y/Pb/Pr is queued.
// A clocked monitor pops that queue on every out_valid strobe and compares the
// three fields. max_value is rewritten only with the pipeline drained.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX  = 10;

  localparam longint unsigned Y_R  = 19595;
  localparam longint unsigned Y_G  = 38470;
  localparam longint unsigned Y_B  = 7471;
  localparam longint unsigned PB_R = 11058;
  localparam longint unsigned PB_G = 21710;
  localparam longint unsigned PR_G = 27439;
  localparam longint unsigned PR_B = 5329;
  localparam longint unsigned HALF_SCALE = 32768;
  localparam longint unsigned LUMA_TOP   = 32768;
  localparam longint unsigned DIFF_TOP   = 16384;
  localparam int              FRAC       = 15;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [15:0] luma;
    logic [15:0] pb;
    logic [15:0] pr;
  } ypbpr_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_red = '0;
  logic [15:0] in_green = '0;
  logic [15:0] in_blue = '0;
  logic        out_valid;
  logic [15:0] out_luma;
  logic signed [15:0] out_blue_diff;
  logic signed [15:0] out_red_diff;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  pixel_t      pixel_q[$];
  ypbpr_t      ypbpr_q[$];
  pixel_t      cur_px;
  ypbpr_t      want;
  logic [15:0] max_shadow = 16'd255;
  logic        calm = 1'b0;
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;

  rgb_to_ypbpr_converter_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (out_valid),
    .out_luma     (out_luma),
    .out_blue_diff(out_blue_diff),
    .out_red_diff (out_red_diff),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rounded (pos - neg) * 2^15 / (m * 2^16), ties away from zero, clamped to
  // neg_top below zero and pos_top above.
  function automatic logic [15:0] scale_clamp(input longint unsigned pos,
                                              input longint unsigned neg,
                                              input longint unsigned m,
                                              input longint unsigned neg_top,
                                              input longint unsigned pos_top);
    logic            below;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    below = neg > pos;
    mag = below ? neg - pos : pos - neg;
    den = m << 16;
    q = ((mag << FRAC) + (den >> 1)) / den;
    if (below) begin
      if (q > neg_top) q = neg_top;
      return 16'(64'd0 - q);
    end
    if (q > pos_top) q = pos_top;
    return 16'(q);
  endfunction

  function automatic ypbpr_t convert_pixel(input pixel_t px, input logic [15:0] maxv);
    longint unsigned r;
    longint unsigned g;
    longint unsigned b;
    longint unsigned m;
    ypbpr_t          res;
    r = px.red;
    g = px.green;
    b = px.blue;
    m = (maxv == 16'd0) ? 1 : maxv;
    res.luma = scale_clamp(Y_R * r + Y_G * g + Y_B * b, 0, m, 0, LUMA_TOP);
    res.pb = scale_clamp(HALF_SCALE * b, PB_R * r + PB_G * g, m, DIFF_TOP, DIFF_TOP);
    res.pr = scale_clamp(HALF_SCALE * r, PR_G * g + PR_B * b, m, DIFF_TOP, DIFF_TOP);
    return res;
  endfunction

  // Mostly in range, with some at the bounds, just above, and fully random.
  function automatic logic [15:0] rand_sample(input logic [15:0] m);
    logic [15:0] top;
    int unsigned pick;
    top = (m == 16'd0) ? 16'd1 : m;
    pick = $urandom_range(9);
    case (pick)
      0: return 16'($urandom);
      1: return 16'd0;
      2: return top;
      3: return (top > 16'd65471) ? 16'd65535 : top + 16'($urandom_range(64, 1));
      default: return 16'($urandom_range(top));
    endcase
  endfunction

  // Request driver: hold the request while busy, advance on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) ypbpr_q.push_back(convert_pixel(cur_px, max_shadow));
      if (!start || !busy) begin
        if (pixel_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
          cur_px = pixel_q.pop_front();
          start <= 1'b1;
          in_red <= cur_px.red;
          in_green <= cur_px.green;
          in_blue <= cur_px.blue;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (ypbpr_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected result: Y=%0d Pb=%0d Pr=%0d",
                   out_luma, out_blue_diff, out_red_diff);
      end else begin
        want = ypbpr_q.pop_front();
        if (out_luma !== want.luma || out_blue_diff !== want.pb ||
            out_red_diff !== want.pr) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("mismatch: exp Y=%0d Pb=%0d Pr=%0d got Y=%0d Pb=%0d Pr=%0d",
                     want.luma, $signed(want.pb), $signed(want.pr),
                     out_luma, out_blue_diff, out_red_diff);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_q.size() != 0 || start || ypbpr_q.size() != 0);
  endtask

  task automatic write_max(input logic [15:0] v);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_shadow = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pixel(input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    pixel_q.push_back(px);
  endtask

  task automatic queue_random(input int count, input logic [15:0] m);
    repeat (count) queue_pixel(rand_sample(m), rand_sample(m), rand_sample(m));
  endtask

  initial begin
    logic [15:0] settings[7];
    settings = '{16'd1, 16'd65535, 16'd0, 16'd1023, 16'd100, 16'd0, 16'd255};
    settings[5] = 16'($urandom_range(65535, 2));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels at the reset max_value of 255.
    queue_pixel(16'd0, 16'd0, 16'd0);
    queue_pixel(16'd255, 16'd255, 16'd255);
    queue_pixel(16'd255, 16'd0, 16'd0);
    queue_pixel(16'd0, 16'd255, 16'd0);
    queue_pixel(16'd0, 16'd0, 16'd255);
    queue_pixel(16'd0, 16'd255, 16'd255);
    queue_pixel(16'd255, 16'd0, 16'd255);
    queue_pixel(16'd255, 16'd255, 16'd0);
    queue_pixel(16'd65535, 16'd65535, 16'd65535);
    queue_pixel(16'd65535, 16'd0, 16'd0);
    queue_pixel(16'd0, 16'd65535, 16'd0);
    queue_pixel(16'd0, 16'd0, 16'd65535);
    queue_pixel(16'd0, 16'd65535, 16'd65535);
    queue_pixel(16'd65535, 16'd0, 16'd65535);
    queue_pixel(16'd65535, 16'd65535, 16'd0);
    queue_pixel(16'd128, 16'd128, 16'd128);
    queue_pixel(16'd1, 16'd0, 16'd0);
    queue_pixel(16'd256, 16'd0, 16'd0);
    queue_random(120, max_shadow);

    foreach (settings[i]) begin
      write_max(settings[i]);
      // One full-rate stretch with no gaps at all.
      calm = (i == 1);
      queue_random(120, settings[i]);
    end

    wait_drained();
    calm = 1'b0;
    repeat (rtyc_pkg::PIPE_DEPTH + 5) @(posedge clk);
    if (mismatch_cnt == 0 && ypbpr_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
